/* hdl/srr_pkg.sv */
// ----------------------------------------------------------------------------
// srr_pkg
// Types, codes and defaults shared by the selective-repeat receiver modules.
// ----------------------------------------------------------------------------
package srr_pkg;

  localparam int unsigned SeqSpaceDef    = 8;
  localparam int unsigned PayloadBitsDef = 32;
  localparam int unsigned SeqW           = 8;
  localparam int unsigned WordW          = 32;

  // result kind codes
  localparam logic KIND_ACK     = 1'b0;
  localparam logic KIND_DELIVER = 1'b1;

  typedef struct packed {
    logic [SeqW-1:0]  seq_num;
    logic             checksum_ok;
    logic [WordW-1:0] payload_word;
  } srr_in_t;

  typedef struct packed {
    logic             result_kind;
    logic [SeqW-1:0]  ack_num;
    logic [WordW-1:0] delivered_payload;
    logic             last;
  } srr_out_t;

  // intact packet as handed from the front to the back
  typedef struct packed {
    logic [SeqW-1:0]  seq_num;
    logic             in_range;
    logic [WordW-1:0] payload_word;
  } srr_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT
  } back_state_e;

endpackage

/* hdl/selective_repeat_receiver_core.sv */
// ----------------------------------------------------------------------------
// selective_repeat_receiver_core
// Selective-repeat ARQ receiver: drops corrupt packets, acknowledges intact
// ones, buffers those in the window and delivers in-order runs upward.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o   srr_in_t  (one packet)
//   out      output     out_valid_o / out_stall_i srr_out_t (ack or delivery)
//
// An acknowledgement is registered by the back end from its idle state; a run of
// in-order deliveries goes through ST_READ for the slot memory read, then ST_EMIT.
// A two-entry queue sits between front and back, so the front takes up to two
// packets ahead while the back delivers or the output is stalled, then stalls.
// Reset clears the base, head and slot marks at once; no clearing pass.
// A stall on the output holds the registered result and the back end.
// ----------------------------------------------------------------------------
module selective_repeat_receiver_core #(
  parameter int unsigned SEQ_SPACE    = srr_pkg::SeqSpaceDef,
  parameter int unsigned PAYLOAD_BITS = srr_pkg::PayloadBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  srr_pkg::srr_in_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output srr_pkg::srr_out_t out_item_o
);
  import srr_pkg::*;

  logic     cmd_valid;
  logic     cmd_pop;
  srr_cmd_t cmd;

  srr_front #(
    .SEQ_SPACE (SEQ_SPACE)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop),
    .cmd_o       (cmd)
  );

  srr_back #(
    .SEQ_SPACE    (SEQ_SPACE),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .cmd_i       (cmd),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

/* hdl/srr_front.sv */
// ----------------------------------------------------------------------------
// srr_front
// Accepts packets, drops corrupt ones, flags sequence numbers beyond the
// space and holds intact packets in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module srr_front #(
  parameter int unsigned SEQ_SPACE = srr_pkg::SeqSpaceDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  srr_pkg::srr_in_t  in_item_i,
  output logic              cmd_valid_o,
  input  logic              cmd_pop_i,
  output srr_pkg::srr_cmd_t cmd_o
);
  import srr_pkg::*;

  localparam logic [SeqW:0] SpaceLim = (SeqW + 1)'(SEQ_SPACE);

  logic [1:0] cnt_q, cnt_d;
  logic       wr_q, rd_q;
  logic       push, pop;
  srr_cmd_t   cmd_in;
  srr_cmd_t   buf_q [2];

  assign in_stall_o  = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign push        = in_valid_i && !in_stall_o && in_item_i.checksum_ok;
  assign pop         = cmd_pop_i && cmd_valid_o;

  always_comb begin
    cmd_in.seq_num      = in_item_i.seq_num;
    cmd_in.in_range     = ({1'b0, in_item_i.seq_num} < SpaceLim);
    cmd_in.payload_word = in_item_i.payload_word;
  end

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_q <= !wr_q;
      end
      if (pop) begin
        rd_q <= !rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_q] <= cmd_in;
    end
  end

  assign cmd_o = buf_q[rd_q];

endmodule

/* hdl/srr_back.sv */
// ----------------------------------------------------------------------------
// srr_back
// Keeps the receive window: buffers in-window packets, acknowledges every
// intact packet and delivers the run of filled slots from the base in order.
// Slots live in a circular buffer; the head pointer follows the window base.
// ----------------------------------------------------------------------------
module srr_back #(
  parameter int unsigned SEQ_SPACE    = srr_pkg::SeqSpaceDef,
  parameter int unsigned PAYLOAD_BITS = srr_pkg::PayloadBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  output logic              cmd_pop_o,
  input  srr_pkg::srr_cmd_t cmd_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output srr_pkg::srr_out_t out_item_o
);
  import srr_pkg::*;

  localparam int unsigned Win   = SEQ_SPACE / 2;
  localparam int unsigned HW    = (Win > 1) ? $clog2(Win) : 1;
  localparam int unsigned BW    = $clog2(SEQ_SPACE);
  localparam int unsigned SlotW = (PAYLOAD_BITS < WordW) ? PAYLOAD_BITS : WordW;

  localparam logic [BW:0]   Space   = (BW + 1)'(SEQ_SPACE);
  localparam logic [BW:0]   WinOff  = (BW + 1)'(Win);
  localparam logic [HW:0]   WinExt  = (HW + 1)'(Win);
  localparam logic [BW-1:0] BaseMax = BW'(SEQ_SPACE - 1);
  localparam logic [HW-1:0] HeadMax = HW'(Win - 1);

  back_state_e state_q, state_d;

  logic [BW-1:0]  base_q, base_d;
  logic [HW-1:0]  head_q, head_d;
  logic [Win-1:0] filled_q, filled_d;
  logic           out_valid_q, out_valid_d;
  srr_out_t       out_q, out_d;

  logic [SlotW-1:0] slot_mem [Win];
  logic [SlotW-1:0] rd_data_q;

  logic [BW:0]   diff, off;
  logic          in_win, at_base;
  logic [HW:0]   addr_sum, addr_wrap;
  logic [HW-1:0] wr_addr, rd_addr, head_inc;
  logic          out_free, mem_we, ld_out, advance;

  assign out_free = !out_valid_q || !out_stall_i;
  assign head_inc = (head_q == HeadMax) ? '0 : head_q + HW'(1);

  // offset of the packet from the window base, modulo the sequence space
  always_comb begin
    diff      = {1'b0, cmd_i.seq_num[BW-1:0]} - {1'b0, base_q};
    off       = diff[BW] ? diff + Space : diff;
    in_win    = cmd_i.in_range && (off < WinOff);
    at_base   = in_win && (off == '0);
    addr_sum  = {1'b0, head_q} + {1'b0, off[HW-1:0]};
    addr_wrap = addr_sum - WinExt;
    wr_addr   = (addr_sum >= WinExt) ? addr_wrap[HW-1:0] : addr_sum[HW-1:0];
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && out_free && at_base) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free && !filled_q[head_inc]) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // outputs and datapath control
  always_comb begin
    cmd_pop_o = 1'b0;
    mem_we    = 1'b0;
    ld_out    = 1'b0;
    advance   = 1'b0;
    out_d     = out_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && out_free) begin
          cmd_pop_o               = 1'b1;
          ld_out                  = 1'b1;
          out_d.result_kind       = KIND_ACK;
          out_d.ack_num           = cmd_i.seq_num;
          out_d.delivered_payload = '0;
          out_d.last              = !at_base;
          // keep the first copy of a duplicate
          mem_we                  = in_win && !filled_q[wr_addr];
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          ld_out                  = 1'b1;
          advance                 = 1'b1;
          out_d.result_kind       = KIND_DELIVER;
          out_d.ack_num           = '0;
          out_d.delivered_payload = WordW'(rd_data_q);
          out_d.last              = !filled_q[head_inc];
        end
      end
      default: begin
      end
    endcase
  end

  // read ahead at the next slot while the current one goes out
  assign rd_addr = advance ? head_inc : head_q;

  always_comb begin
    filled_d = filled_q;
    base_d   = base_q;
    head_d   = head_q;
    if (mem_we) begin
      filled_d[wr_addr] = 1'b1;
    end
    if (advance) begin
      filled_d[head_q] = 1'b0;
      head_d           = head_inc;
      base_d           = (base_q == BaseMax) ? '0 : base_q + BW'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ld_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      base_q      <= '0;
      head_q      <= '0;
      filled_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      base_q      <= base_d;
      head_q      <= head_d;
      filled_q    <= filled_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_out) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem[wr_addr] <= cmd_i.payload_word[SlotW-1:0];
    end
    rd_data_q <= slot_mem[rd_addr];
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // the base slot is always empty between packets
  a_base_empty_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !filled_q[head_q])
    else $error("base slot filled while idle");

  a_emit_filled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> filled_q[head_q])
    else $error("delivering from an empty slot");

  a_read_then_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |=> (state_q == ST_EMIT))
    else $error("memory read not followed by delivery");

  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !cmd_pop_o)
    else $error("packet taken while a run is in delivery");

endmodule
